/* rtl/euq_pkg.sv */
// Package for the Euler-angle to quaternion converter.
// Holds the item types, the CORDIC angle table and the fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package euq_pkg;

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANG_TAB_LEN = 32;
  localparam int CORDIC_N = (CORDIC_ITERATIONS > ANG_TAB_LEN) ? ANG_TAB_LEN
                                                              : CORDIC_ITERATIONS;

  // Angle units are 2^-40 rad; the residual angle needs 44 bits with sign.
  localparam int ZW = 44;
  // CORDIC x and y are Q30 with headroom.
  localparam int XW = 33;

  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
  localparam int HALF_TURN = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int FULL_TURN = 46080;
  localparam int Q14_ONE = 16384;

  typedef logic signed [ZW-1:0] ang_tab_t [ANG_TAB_LEN];

  // Restoring unsigned divider, used only while building constants.
  function automatic logic [63:0] udiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in 2^-40 rad units, truncated integer Taylor series.
  function automatic logic signed [63:0] atan_recip(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    p = udiv(64'd1 << 40, n);
    nn = n * n;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = $signed(udiv(p, 64'(2 * k + 1)));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
        p = udiv(p, nn);
      end
    end
    return sum;
  endfunction

  function automatic ang_tab_t build_ang_tab();
    ang_tab_t t;
    t[0] = ZW'(atan_recip(64'd2) + atan_recip(64'd3));
    for (int i = 1; i < ANG_TAB_LEN; i++) begin
      t[i] = ZW'(atan_recip(64'd1 << i));
    end
    return t;
  endfunction

  localparam ang_tab_t ANG_TAB = build_ang_tab();
  localparam longint PI_UNITS = 4 * longint'(ANG_TAB[0]);

  // z = r * pi / 23040 is split as r*PI_QUO + floor(r*PI_REM / 23040).
  // 23040 = 512 * 45; the divide by 45 is a reciprocal multiply that is
  // exact for every value below 2^20.
  localparam longint PI_QUO = PI_UNITS / HALF_TURN;
  localparam longint PI_REM = PI_UNITS % HALF_TURN;
  localparam int REC_SHIFT = 26;
  localparam longint REC_MULT = ((longint'(1) << REC_SHIFT) + 44) / 45;

endpackage

/* rtl/euler_to_quaternion.sv */
// Euler-angle (ZYX) to unit quaternion converter, fully pipelined.
// Throughput: one item per cycle; the whole pipe advances together and
// holds when the output register is full and not taken.
// Reset: synchronous, active high; clears all stage valid bits only.
`timescale 1ns / 1ps

module euler_to_quaternion (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   angles_valid,
  output logic                   angles_ready,
  input  euq_pkg::angles_t       angles,
  output logic                   quat_valid,
  input  logic                   quat_ready,
  output euq_pkg::quat_t         quat
);

  localparam int N = euq_pkg::CORDIC_N;
  localparam int XW = euq_pkg::XW;
  localparam int ZW = euq_pkg::ZW;
  // Stages: fold, split multiply, angle sum, N CORDIC steps, sign fix,
  // first products, second products, sum and round.
  localparam int NST = N + 7;

  logic [NST-1:0] vld;
  logic           adv;

  // The pipe moves whenever the output register is empty or being taken.
  assign adv = !vld[NST-1] || quat_ready;
  assign angles_ready = adv;
  assign quat_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], angles_valid};
    end
  end

  // Stage A: wrap the half angle into [-180, 180) degrees and fold it into
  // [-90, 90], remembering whether sine and cosine must be negated.
  logic [13:0] a_mag  [3];
  logic        a_zneg [3];
  logic        a_flip [3];
  logic signed [15:0] raw [3];

  assign raw[0] = angles.roll_deg;
  assign raw[1] = angles.pitch_deg;
  assign raw[2] = angles.yaw_deg;

  for (genvar a = 0; a < 3; a++) begin : g_fold
    logic signed [17:0] rw;
    logic signed [17:0] rf;
    logic               fl;
    always_comb begin
      rw = 18'(raw[a]);
      if (rw >= 18'sd23040) begin
        rw = rw - 18'sd46080;
      end else if (rw < -18'sd23040) begin
        rw = rw + 18'sd46080;
      end
      fl = 1'b0;
      rf = rw;
      if (rw > 18'sd11520) begin
        rf = rw - 18'sd23040;
        fl = 1'b1;
      end else if (rw < -18'sd11520) begin
        rf = rw + 18'sd23040;
        fl = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        a_zneg[a] <= rf[17];
        a_flip[a] <= fl;
        a_mag[a]  <= rf[17] ? 14'(-rf) : 14'(rf);
      end
    end
  end

  // Stage B: magnitude times the quotient and remainder of pi / 23040.
  logic [41:0] b_pq   [3];
  logic [28:0] b_pr   [3];
  logic        b_zneg [3];
  logic        b_flip [3];

  // Stage C and CORDIC: x, y, residual angle and negate flag per step.
  logic signed [XW-1:0] cx [N+1][3];
  logic signed [XW-1:0] cy [N+1][3];
  logic signed [ZW-1:0] cz [N+1][3];
  logic                 cf [N+1][3];

  for (genvar a = 0; a < 3; a++) begin : g_conv
    logic [19:0] hi;
    logic [40:0] qp;
    logic [ZW-1:0] mz;
    always_comb begin
      hi = b_pr[a][28:9];
      qp = 41'(hi) * 41'(euq_pkg::REC_MULT);
      mz = ZW'(b_pq[a]) + ZW'(qp >> euq_pkg::REC_SHIFT);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        b_pq[a]   <= 42'(a_mag[a]) * 42'(euq_pkg::PI_QUO);
        b_pr[a]   <= 29'(a_mag[a]) * 29'(euq_pkg::PI_REM);
        b_zneg[a] <= a_zneg[a];
        b_flip[a] <= a_flip[a];
        cz[0][a]  <= b_zneg[a] ? -$signed(mz) : $signed(mz);
        cx[0][a]  <= euq_pkg::GAIN_Q30;
        cy[0][a]  <= '0;
        cf[0][a]  <= b_flip[a];
      end
    end
  end

  // One CORDIC rotation per stage; zero residual counts as positive.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    for (genvar a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clk) begin
        if (adv) begin
          cf[i+1][a] <= cf[i][a];
          if (!cz[i][a][ZW-1]) begin
            cx[i+1][a] <= cx[i][a] - (cy[i][a] >>> i);
            cy[i+1][a] <= cy[i][a] + (cx[i][a] >>> i);
            cz[i+1][a] <= cz[i][a] - euq_pkg::ANG_TAB[i];
          end else begin
            cx[i+1][a] <= cx[i][a] + (cy[i][a] >>> i);
            cy[i+1][a] <= cy[i][a] - (cx[i][a] >>> i);
            cz[i+1][a] <= cz[i][a] + euq_pkg::ANG_TAB[i];
          end
        end
      end
    end
  end

  // Stage D: undo the fold by negating both sine and cosine.
  logic signed [XW-1:0] d_c [3];
  logic signed [XW-1:0] d_s [3];

  for (genvar a = 0; a < 3; a++) begin : g_fix
    always_ff @(posedge clk) begin
      if (adv) begin
        d_c[a] <= cf[N][a] ? -cx[N][a] : cx[N][a];
        d_s[a] <= cf[N][a] ? -cy[N][a] : cy[N][a];
      end
    end
  end

  function automatic logic signed [XW-1:0] mul30(logic signed [XW-1:0] p,
                                                 logic signed [XW-1:0] q);
    logic signed [2*XW-1:0] m;
    m = (2*XW)'(p) * (2*XW)'(q);
    return m[XW+29:30];
  endfunction

  // Stage E: yaw-pitch products, with roll carried along.
  logic signed [XW-1:0] e_cycp, e_sysp, e_cysp, e_sycp, e_cr, e_sr;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_cycp <= mul30(d_c[2], d_c[1]);
      e_sysp <= mul30(d_s[2], d_s[1]);
      e_cysp <= mul30(d_c[2], d_s[1]);
      e_sycp <= mul30(d_s[2], d_c[1]);
      e_cr   <= d_c[0];
      e_sr   <= d_s[0];
    end
  end

  // Stage F: the eight products with the roll terms.
  logic signed [XW-1:0] f_w1, f_w2, f_x1, f_x2, f_y1, f_y2, f_z1, f_z2;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_w1 <= mul30(e_cycp, e_cr);
      f_w2 <= mul30(e_sysp, e_sr);
      f_x1 <= mul30(e_cycp, e_sr);
      f_x2 <= mul30(e_sysp, e_cr);
      f_y1 <= mul30(e_cysp, e_cr);
      f_y2 <= mul30(e_sycp, e_sr);
      f_z1 <= mul30(e_sycp, e_cr);
      f_z2 <= mul30(e_cysp, e_sr);
    end
  end

  // Q30 to Q14 with round half up, then clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(logic signed [XW:0] v);
    logic signed [XW+1:0] r;
    logic signed [XW+1:0] q;
    r = (XW+2)'(v) + (XW+2)'(32768);
    q = r >>> 16;
    if (q > (XW+2)'(euq_pkg::Q14_ONE)) begin
      q = (XW+2)'(euq_pkg::Q14_ONE);
    end else if (q < -(XW+2)'(euq_pkg::Q14_ONE)) begin
      q = -(XW+2)'(euq_pkg::Q14_ONE);
    end
    return q[15:0];
  endfunction

  // Stage G: output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      quat.quat_w <= to_q14((XW+1)'(f_w1) + (XW+1)'(f_w2));
      quat.quat_x <= to_q14((XW+1)'(f_x1) - (XW+1)'(f_x2));
      quat.quat_y <= to_q14((XW+1)'(f_y1) + (XW+1)'(f_y2));
      quat.quat_z <= to_q14((XW+1)'(f_z1) - (XW+1)'(f_z2));
    end
  end

endmodule
